// ----- src/bitmap_page_frame_allocator_core_defines.svh -----
// assertion macros used by the checker file of the frame allocator
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bpfa_pkg.sv -----
// shared types and constants of the bitmap page frame allocator
package bpfa_pkg;

    localparam int NUM_FRAMES_DEF = 65536;

    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 49;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 17;
    localparam int FRAME_SHIFT = 12;

    // bitmap word layout
    localparam int WORD_W         = 64;
    localparam int BIT_IDX_W      = 6;
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int BYTE_IDX_W     = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 72;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 17'h10000;

    // request modes
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd3;

endpackage

// ----- src/bpfa_ram.sv -----
// generic single-write, single-read ram with registered read data
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/bitmap_page_frame_allocator_core.sv -----
// top level of the bitmap page frame allocator (first fit, one bit per 4 KiB frame)
//
// channel   dir  handshake               payload
// s_        in   s_tvalid / s_tready     tuser: mode; tdata: phys_addr, range_length
// m_        out  m_tvalid / m_tready     tuser: status; tdata: frame_addr, used_count
// cfg_      in   cfg_valid / cfg_ready   cfg_data: frame_count
//
// after reset a sweep writes all-ones into every bitmap word (1024 words at
// 65536 frames) with s_tready low; cfg_ready is always high
// after acceptance: setup, then read and check per word (each word touched by a
// range op, each word scanned by alloc, the one word of a free), the bit pick for
// alloc, then post; the sequencer idles before the next request is accepted
// a stalled m_ side holds the result; the next transaction runs and waits to post
module bitmap_page_frame_allocator_core #(
    parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request: tuser = mode[1:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata = phys_addr[47:0], range_length[96:48], zero pad
    input  logic [bpfa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [bpfa_pkg::MODE_W-1:0]    s_tuser,
    // result: tuser = status[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata = frame_addr[47:0], used_count[64:48], zero pad
    output logic [bpfa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [bpfa_pkg::STATUS_W-1:0]  m_tuser,
    // frame_count register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpfa_pkg::COUNT_W-1:0]   cfg_data
);
    import bpfa_pkg::*;

    // bitmap geometry
    localparam int DEPTH   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FRAME_W = WADDR_W + BIT_IDX_W;
    localparam int LIM_W   = FRAME_W + 1;
    localparam int SF_W    = ADDR_W - FRAME_SHIFT;
    localparam int EF_W    = ADDR_W + 2 - FRAME_SHIFT;

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_INIT  = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_SETUP = 3'd2;
    localparam logic [ST_W-1:0] ST_READ  = 3'd3;
    localparam logic [ST_W-1:0] ST_CHECK = 3'd4;
    localparam logic [ST_W-1:0] ST_FIND  = 3'd5;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd6;

    logic [ST_W-1:0]       state_reg, state_next;
    logic [WADDR_W-1:0]    wa_reg, wa_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [FRAME_W-1:0]    s_reg, s_next;
    logic [FRAME_W-1:0]    e_last_reg, e_last_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    fc_reg, fc_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     res_faddr_reg, res_faddr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ADDR_W-1:0]     out_faddr_reg, out_faddr_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    // bitmap ram port
    logic                  ram_we;
    logic [WADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [WORD_W-1:0]     ram_rdata;

    // shared word unit signals
    logic [LIM_W-1:0]      lim;
    logic [SF_W-1:0]       s_full;
    logic [ADDR_W+1:0]     end_sum;
    logic [EF_W-1:0]       e_full;
    logic [LIM_W-1:0]      s_clip;
    logic [LIM_W-1:0]      e_clip;
    logic [BIT_IDX_W-1:0]  first_bit;
    logic [BIT_IDX_W-1:0]  last_bit;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     free_bits;
    logic                  any_free;
    logic [BYTE_IDX_W-1:0] sel_idx;
    logic [BYTE_W-1:0]     sel_byte;
    logic [BYTE_IDX_W-1:0] bit_sel;
    logic [BIT_IDX_W-1:0]  bit_idx;
    logic                  last_word;

    bpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(WADDR_W)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(wa_reg),
        .rdata(ram_rdata)
    );

    // effective limit: min(frame_count, NUM_FRAMES)
    assign lim = ({15'b0, fc_reg} < 32'(NUM_FRAMES)) ? LIM_W'(fc_reg) : LIM_W'(NUM_FRAMES);

    // range bounds in frames, clipped to the limit
    assign s_full  = addr_reg[ADDR_W-1:FRAME_SHIFT];
    assign end_sum = {2'b0, addr_reg} + {1'b0, len_reg};
    assign e_full  = end_sum[ADDR_W+1:FRAME_SHIFT];
    assign s_clip  = (s_full > SF_W'(lim)) ? lim : LIM_W'(s_full);
    assign e_clip  = (e_full > EF_W'(lim)) ? lim : LIM_W'(e_full);

    // bit mask of frames [s_reg, e_last_reg] inside the current word
    assign last_word = (wa_reg == e_last_reg[FRAME_W-1:BIT_IDX_W]);
    assign first_bit = (wa_reg == s_reg[FRAME_W-1:BIT_IDX_W]) ? s_reg[BIT_IDX_W-1:0] : '0;
    assign last_bit  = last_word ? e_last_reg[BIT_IDX_W-1:0] : BIT_IDX_W'(WORD_W - 1);
    assign mask      = ({WORD_W{1'b1}} << first_bit)
                     & ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - last_bit));
    assign free_bits = ~ram_rdata & mask;
    assign any_free  = |free_bits;

    // first free frame, step one: lowest byte holding a clear bit
    always_comb
    begin
        sel_idx  = '0;
        sel_byte = '0;
        for (int i = BYTES_PER_WORD - 1; i >= 0; i--)
        begin
            if (|free_bits[i*BYTE_W +: BYTE_W])
            begin
                sel_idx  = BYTE_IDX_W'(i);
                sel_byte = free_bits[i*BYTE_W +: BYTE_W];
            end
        end
    end

    // step two: lowest set bit of the registered byte
    always_comb
    begin
        bit_sel = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (byte_reg[i])
            begin
                bit_sel = BYTE_IDX_W'(i);
            end
        end
    end

    assign bit_idx = {byte_idx_reg, bit_sel};

    always_comb
    begin
        state_next      = state_reg;
        wa_next         = wa_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        s_next          = s_reg;
        e_last_next     = e_last_reg;
        word_next       = word_reg;
        byte_next       = byte_reg;
        byte_idx_next   = byte_idx_reg;
        count_next      = count_reg;
        fc_next         = cfg_valid ? cfg_data : fc_reg;
        res_status_next = res_status_reg;
        res_faddr_next  = res_faddr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_faddr_next  = out_faddr_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = wa_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // mark every frame used
                ram_we    = 1'b1;
                ram_wdata = {WORD_W{1'b1}};
                if (wa_reg == WADDR_W'(DEPTH - 1))
                begin
                    wa_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wa_next = wa_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    addr_next  = s_tdata[ADDR_W-1:0];
                    len_next   = s_tdata[ADDR_W +: LEN_W];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                res_status_next = STATUS_OK;
                res_faddr_next  = '0;
                unique case (mode_reg)
                    MODE_RELEASE, MODE_RESERVE:
                    begin
                        if (s_clip >= e_clip)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            s_next      = FRAME_W'(s_clip);
                            e_last_next = FRAME_W'(e_clip - 1'b1);
                            wa_next     = s_clip[FRAME_W-1:BIT_IDX_W];
                            state_next  = ST_READ;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        if (lim == '0)
                        begin
                            res_status_next = STATUS_NO_FREE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            s_next      = '0;
                            e_last_next = FRAME_W'(lim - 1'b1);
                            wa_next     = '0;
                            state_next  = ST_READ;
                        end
                    end
                    default:
                    begin
                        // free: single-frame range
                        if (s_full >= SF_W'(lim))
                        begin
                            res_status_next = STATUS_OUT_RANGE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            s_next      = FRAME_W'(s_full);
                            e_last_next = FRAME_W'(s_full);
                            wa_next     = s_full[FRAME_W-1:BIT_IDX_W];
                            state_next  = ST_READ;
                        end
                    end
                endcase
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                unique case (mode_reg)
                    MODE_RELEASE, MODE_RESERVE:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (mode_reg == MODE_RESERVE) ? (ram_rdata | mask)
                                                               : (ram_rdata & ~mask);
                        if (last_word)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            wa_next    = wa_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        if (any_free)
                        begin
                            word_next     = ram_rdata;
                            byte_next     = sel_byte;
                            byte_idx_next = sel_idx;
                            state_next    = ST_FIND;
                        end
                        else if (last_word)
                        begin
                            res_status_next = STATUS_NO_FREE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            wa_next    = wa_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        if (|(ram_rdata & mask))
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~mask;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = STATUS_NOT_ALLOC;
                        end
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FIND:
            begin
                ram_we         = 1'b1;
                ram_wdata      = word_reg | ({{(WORD_W-1){1'b0}}, 1'b1} << bit_idx);
                res_faddr_next = ADDR_W'({wa_reg, bit_idx, {FRAME_SHIFT{1'b0}}});
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // post once the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_faddr_next  = res_faddr_reg;
                    out_count_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            wa_reg        <= '0;
            count_reg     <= '0;
            fc_reg        <= FRAME_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wa_reg        <= wa_next;
            count_reg     <= count_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        s_reg          <= s_next;
        e_last_reg     <= e_last_next;
        word_reg       <= word_next;
        byte_reg       <= byte_next;
        byte_idx_reg   <= byte_idx_next;
        res_status_reg <= res_status_next;
        res_faddr_reg  <= res_faddr_next;
        out_status_reg <= out_status_next;
        out_faddr_reg  <= out_faddr_next;
        out_count_reg  <= out_count_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = M_TDATA_W'({out_count_reg, out_faddr_reg});

endmodule

// ----- src/bpfa_checker.sv -----
// port-level checks of the frame allocator, bound to the top level
`include "bitmap_page_frame_allocator_core_defines.svh"

module bpfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bpfa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bpfa_pkg::STATUS_W-1:0]  m_tuser
);
    import bpfa_pkg::*;

    // a stalled result holds
    `BPFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one request at a time: no back-to-back acceptance
    `BPFA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // frame address only on a successful result
    `BPFA_ASSERT_NOW(a_addr_zero, m_tvalid && (m_tuser != STATUS_OK), m_tdata[ADDR_W-1:0] == '0, "frame address on failed result")

    // frame addresses are page aligned
    `BPFA_ASSERT_NOW(a_addr_aligned, m_tvalid, m_tdata[FRAME_SHIFT-1:0] == '0, "unaligned frame address")

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (.*);

// ----- bench/testbench.sv -----
// self-checking testbench of the bitmap page frame allocator core
`timescale 1ns / 100ps

module testbench;
    import bpfa_pkg::*;

    // cycles with no transaction on any channel before the run is declared hung
    localparam int QUIET_LIMIT   = 30000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 32;
    localparam int PHASE_ITEMS   = 93;
    localparam int PHASE_COUNT   = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   frame_addr;
        logic [COUNT_W-1:0]  used_count;
    } alloc_result_t;

    // mirror of the frame bitmap, the used counter and frame_count
    class frame_pool_mirror;
        bit [NUM_FRAMES_DEF-1:0] used_bits;
        logic [COUNT_W-1:0]      used_counter;
        logic [COUNT_W-1:0]      frame_count;
        alloc_result_t           awaited_results[$];
        int                      mismatch_count;

        function new();
            used_bits      = '1;
            used_counter   = '0;
            frame_count    = FRAME_COUNT_RST;
            mismatch_count = 0;
        endfunction

        // apply one accepted request and queue the result it must produce
        function void apply_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                                    logic [LEN_W-1:0] len);
            longint unsigned lim;
            longint unsigned first;
            longint unsigned stop;
            longint unsigned f;
            alloc_result_t   r;
            lim = (64'(frame_count) < 64'(NUM_FRAMES_DEF)) ? 64'(frame_count)
                                                            : 64'(NUM_FRAMES_DEF);
            r.status     = STATUS_OK;
            r.frame_addr = '0;
            if (mode == MODE_RELEASE || mode == MODE_RESERVE)
            begin
                // frames floor(addr/4K) up to floor((addr+len)/4K), both clipped
                first = 64'(addr) >> FRAME_SHIFT;
                stop  = (64'(addr) + 64'(len)) >> FRAME_SHIFT;
                if (first > lim)
                    first = lim;
                if (stop > lim)
                    stop = lim;
                for (f = first; f < stop; f++)
                    used_bits[f] = (mode == MODE_RESERVE);
            end
            else if (mode == MODE_ALLOC)
            begin
                f = 0;
                while (f < lim && used_bits[f])
                    f++;
                if (f < lim)
                begin
                    used_bits[f] = 1'b1;
                    if (used_counter != COUNT_MAX)
                        used_counter = used_counter + 1'b1;
                    r.frame_addr = ADDR_W'(f << FRAME_SHIFT);
                end
                else
                    r.status = STATUS_NO_FREE;
            end
            else
            begin
                f = 64'(addr) >> FRAME_SHIFT;
                if (f >= lim)
                    r.status = STATUS_OUT_RANGE;
                else if (used_bits[f])
                begin
                    used_bits[f] = 1'b0;
                    // counter saturates at zero when a reserved frame is freed
                    if (used_counter != '0)
                        used_counter = used_counter - 1'b1;
                end
                else
                    r.status = STATUS_NOT_ALLOC;
            end
            r.used_count = used_counter;
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] frame_addr,
                                   logic [COUNT_W-1:0] used_count);
            alloc_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none awaited: status %0d frame_addr %h used_count %0d",
                         $time, status, frame_addr, used_count);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                mismatch_count++;
            end
            if (frame_addr !== want.frame_addr)
            begin
                $display("%0t: frame_addr expected %h actual %h", $time, want.frame_addr,
                         frame_addr);
                mismatch_count++;
            end
            if (used_count !== want.used_count)
            begin
                $display("%0t: used_count expected %0d actual %0d", $time, want.used_count,
                         used_count);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // phys_addr[47:0], range_length[96:48], zero pad
    logic [MODE_W-1:0]    s_tuser;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // frame_addr[47:0], used_count[64:48], zero pad
    logic [STATUS_W-1:0]  m_tuser;   // status[1:0]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    frame_pool_mirror pool = new();
    bit               bursty = 1'b1;   // random idling on both sides
    int               quiet_cycles = 0;

    bitmap_page_frame_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: every accepted result is checked against the oldest one awaited
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pool.check_result(m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+COUNT_W-1:ADDR_W]);
    end

    // result side back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (bursty && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // hang detection: no transaction on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one request transaction; valid stays high for a back-to-back follower
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] len);
        if (bursty && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, len, addr};
        do
            @(posedge clk);
        while (!s_tready);
        pool.apply_request(mode, addr, len);
    endtask

    // frame_count is only written with no request in flight
    task automatic write_frame_count(input logic [COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pool.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool.frame_count = value;
    endtask

    // mostly requests on frames around the low end of the pool, since alloc is
    // first fit; the rest raw field values and whole-pool ranges
    task automatic send_random(input int span);
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        int                pick;
        pick = $urandom_range(0, 99);
        addr = (ADDR_W'($urandom_range(0, span - 1)) << FRAME_SHIFT) |
               ADDR_W'($urandom_range(0, 4095));
        len  = (LEN_W'($urandom_range(0, 48)) << FRAME_SHIFT) | LEN_W'($urandom_range(0, 4095));
        if (pick < 20)
            mode = MODE_RELEASE;
        else if (pick < 30)
            mode = MODE_RESERVE;
        else if (pick < 62)
            mode = MODE_ALLOC;
        else if (pick < 94)
            mode = MODE_FREE;
        else if (pick < 96)
        begin
            // wide range from a low base, clipped at the limit
            mode = ($urandom_range(0, 1) != 0) ? MODE_RESERVE : MODE_RELEASE;
            len  = LEN_W'({$urandom(), $urandom()});
        end
        else
        begin
            mode = MODE_W'($urandom_range(0, 3));
            addr = ADDR_W'({$urandom(), $urandom()});
            len  = LEN_W'({$urandom(), $urandom()});
        end
        send_request(mode, addr, len);
    endtask

    function automatic int window_of(logic [COUNT_W-1:0] fc);
        int lim;
        lim = (fc > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : int'(fc);
        if (lim == 0)
            return 64;
        return (lim + lim / 8 + 2 < 600) ? lim + lim / 8 + 2 : 600;
    endfunction

    initial
    begin
        logic [COUNT_W-1:0] phase_fc [PHASE_COUNT];
        logic [ADDR_W-1:0]  addr_max;
        logic [LEN_W-1:0]   len_max;
        addr_max = '1;
        len_max  = '1;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_RELEASE;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset frame_count, every frame used
        send_request(MODE_ALLOC, addr_max, len_max);                  // nothing free
        send_request(MODE_FREE, '0, '0);                              // counter stays at zero
        send_request(MODE_FREE, '0, '0);                              // frame already clear
        send_request(MODE_FREE, addr_max, '0);                        // far beyond the limit
        send_request(MODE_FREE, ADDR_W'(64'(NUM_FRAMES_DEF) << FRAME_SHIFT), '0);
        send_request(MODE_FREE, ADDR_W'((64'(NUM_FRAMES_DEF - 1) << FRAME_SHIFT) | 'hFFF), '0);
        send_request(MODE_RELEASE, '0, '0);                           // empty range
        send_request(MODE_RELEASE, 'h0FFF, 'h10001);                  // frames 0 to 16
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_FREE, 'h1000, len_max);                     // length ignored
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_RESERVE, 'h3000, 'h2FFF);                   // frames 3 and 4
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_RELEASE, addr_max, len_max);                // clipped to empty
        send_request(MODE_RESERVE, '0, len_max);                      // whole pool used
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_RELEASE, 'hFFFF0800, 'hF800);               // start and end clipped, empty range
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_RELEASE, '0, LEN_W'(1) << (LEN_W - 1));     // whole pool free
        send_request(MODE_ALLOC, '0, '0);
        send_request(MODE_FREE, '0, '0);
        send_request(MODE_FREE, '0, '0);

        // random phases, each under its own frame_count
        phase_fc[0] = 17'd500;
        phase_fc[1] = '0;
        phase_fc[2] = 17'd1;
        phase_fc[3] = FRAME_COUNT_RST;
        phase_fc[4] = 17'd64;
        phase_fc[5] = COUNT_MAX;
        phase_fc[6] = COUNT_W'($urandom_range(65, 4096));
        phase_fc[7] = 17'd70000;
        phase_fc[8] = 17'd4095;
        phase_fc[9] = 17'd300;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_frame_count(phase_fc[p]);
            // last phase runs at full rate on both sides
            if (p == PHASE_COUNT - 1)
                bursty = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random(window_of(phase_fc[p]));
        end

        s_tvalid <= 1'b0;
        while (pool.awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pool.mismatch_count == 0 && pool.awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/bpfa_pkg.sv
src/bpfa_ram.sv
src/bitmap_page_frame_allocator_core.sv
src/bpfa_checker.sv
bench/testbench.sv
